// ===== rtl/core/unique_key_fifo_core_assert.svh =====
// Assertion macros shared by the checkers of this block.
`ifndef UNIQUE_KEY_FIFO_CORE_ASSERT_SVH
`define UNIQUE_KEY_FIFO_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define UKF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define UKF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ukf_pkg.sv =====
package ukf_pkg;

    localparam int DEPTH_DEF = 16;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;
    localparam int STAT_W  = 2;
    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 72;

    typedef logic [STAT_W-1:0] ukf_status_t;

    localparam ukf_status_t ST_OK    = 2'd0;
    localparam ukf_status_t ST_DUP   = 2'd1;
    localparam ukf_status_t ST_EMPTY = 2'd2;
    localparam ukf_status_t ST_FULL  = 2'd3;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_DEQ,
        COND_SCAN_MORE,
        COND_HIT,
        COND_FULL,
        COND_EMPTY,
        COND_OUT_FREE
    } ukf_cond_t;

    typedef logic [3:0] ukf_step_t;

    localparam ukf_step_t STEP_IDLE     = 4'd0;
    localparam ukf_step_t STEP_DISPATCH = 4'd1;
    localparam ukf_step_t STEP_SCAN     = 4'd2;
    localparam ukf_step_t STEP_SETTLE   = 4'd3;
    localparam ukf_step_t STEP_CHK_HIT  = 4'd4;
    localparam ukf_step_t STEP_CHK_FULL = 4'd5;
    localparam ukf_step_t STEP_WRITE    = 4'd6;
    localparam ukf_step_t STEP_DUP      = 4'd7;
    localparam ukf_step_t STEP_FULL     = 4'd8;
    localparam ukf_step_t STEP_DEQ      = 4'd9;
    localparam ukf_step_t STEP_POP      = 4'd10;
    localparam ukf_step_t STEP_EMPTY    = 4'd11;
    localparam ukf_step_t STEP_HEAD_RD  = 4'd12;
    localparam ukf_step_t STEP_EMIT     = 4'd13;
    localparam ukf_step_t STEP_WAIT     = 4'd14;

    typedef struct packed {
        logic        acc;
        logic        scan;
        logic        rd_head;
        logic        wr;
        logic        pop;
        logic        st_load;
        ukf_status_t st;
        logic        emit;
        ukf_cond_t   cond;
        ukf_step_t   target;
    } ukf_ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic is_deq;
        logic scan_more;
        logic hit;
        logic full;
        logic empty;
        logic out_free;
    } ukf_flags_t;

    // Control store: jump to target when the condition holds, else advance.
    function automatic ukf_ctrl_t ucode(input ukf_step_t step);
        ukf_ctrl_t w;
        w = '0;
        w.cond = COND_NEVER;
        w.st = ST_OK;
        case (step)
            STEP_IDLE:
            begin
                w.acc = 1'b1;
                w.cond = COND_NO_INPUT;
                w.target = STEP_IDLE;
            end
            STEP_DISPATCH:
            begin
                w.cond = COND_DEQ;
                w.target = STEP_DEQ;
            end
            STEP_SCAN:
            begin
                w.scan = 1'b1;
                w.cond = COND_SCAN_MORE;
                w.target = STEP_SCAN;
            end
            STEP_SETTLE:
            begin
                w.cond = COND_NEVER;
            end
            STEP_CHK_HIT:
            begin
                w.cond = COND_HIT;
                w.target = STEP_DUP;
            end
            STEP_CHK_FULL:
            begin
                w.cond = COND_FULL;
                w.target = STEP_FULL;
            end
            STEP_WRITE:
            begin
                w.wr = 1'b1;
                w.st_load = 1'b1;
                w.st = ST_OK;
                w.cond = COND_ALWAYS;
                w.target = STEP_HEAD_RD;
            end
            STEP_DUP:
            begin
                w.st_load = 1'b1;
                w.st = ST_DUP;
                w.cond = COND_ALWAYS;
                w.target = STEP_HEAD_RD;
            end
            STEP_FULL:
            begin
                w.st_load = 1'b1;
                w.st = ST_FULL;
                w.cond = COND_ALWAYS;
                w.target = STEP_HEAD_RD;
            end
            STEP_DEQ:
            begin
                w.cond = COND_EMPTY;
                w.target = STEP_EMPTY;
            end
            STEP_POP:
            begin
                w.rd_head = 1'b1;
                w.pop = 1'b1;
                w.st_load = 1'b1;
                w.st = ST_OK;
                w.cond = COND_ALWAYS;
                w.target = STEP_EMIT;
            end
            STEP_EMPTY:
            begin
                w.st_load = 1'b1;
                w.st = ST_EMPTY;
                w.cond = COND_ALWAYS;
                w.target = STEP_EMIT;
            end
            STEP_HEAD_RD:
            begin
                w.rd_head = 1'b1;
                w.cond = COND_NEVER;
            end
            STEP_EMIT:
            begin
                w.emit = 1'b1;
                w.cond = COND_OUT_FREE;
                w.target = STEP_IDLE;
            end
            STEP_WAIT:
            begin
                w.cond = COND_ALWAYS;
                w.target = STEP_EMIT;
            end
            default:
            begin
                w.cond = COND_ALWAYS;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/unique_key_fifo_core.sv =====
// Channel  Dir  Payload
// s_*      in   tuser[0] opcode; tdata key, data
// m_*      out  tuser[1:0] status; tdata key, data, entry_count, is_empty
//
// One item at a time, run by a microcoded step counter over a single-port RAM.
// Dequeue: dispatch, empty check, pop or empty status, emit. Enqueue: scans the
// n entries held, one RAM read per held key while looking for a duplicate.
// The next item is taken in the cycle after the result is loaded.
// Reset clears the step counter, ring pointers and count; no clearing pass.
// A stalled result holds in the output register; the next item waits for it.
module unique_key_fifo_core
    import ukf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [0:0]           s_tuser,   // [0] opcode
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] item_key, [63:32] item_data
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [STAT_W-1:0]    m_tuser,   // [1:0] status
    output logic [M_TDATA_W-1:0] m_tdata    // [31:0] out_key, [63:32] out_data,
                                            // [68:64] entry_count, [69] is_empty
);

    ukf_ctrl_t  ctrl;
    ukf_flags_t flags;

    assign s_tready = ctrl.acc;

    ukf_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    ukf_dp #(
        .DEPTH (DEPTH)
    ) u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .flags    (flags),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== rtl/core/ukf_seq.sv =====
module ukf_seq
    import ukf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ukf_flags_t flags,
    output ukf_ctrl_t  ctrl
);

    ukf_step_t step_reg;
    ukf_step_t step_next;
    logic      cond_true;

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:     cond_true = 1'b0;
            COND_ALWAYS:    cond_true = 1'b1;
            COND_NO_INPUT:  cond_true = !flags.in_valid;
            COND_DEQ:       cond_true = flags.is_deq;
            COND_SCAN_MORE: cond_true = flags.scan_more;
            COND_HIT:       cond_true = flags.hit;
            COND_FULL:      cond_true = flags.full;
            COND_EMPTY:     cond_true = flags.empty;
            COND_OUT_FREE:  cond_true = flags.out_free;
            default:        cond_true = 1'b1;
        endcase
        step_next = cond_true ? ctrl.target : step_reg + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= STEP_IDLE;
        else
            step_reg <= step_next;
    end

endmodule

// ===== rtl/core/ukf_dp.sv =====
module ukf_dp
    import ukf_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  ukf_ctrl_t            ctrl,
    output ukf_flags_t           flags,
    input  logic                 s_tvalid,
    input  logic [0:0]           s_tuser,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [STAT_W-1:0]    m_tuser,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WORD_W = KEY_W + DATA_W;
    localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_reg;

    logic [KEY_W-1:0]  key_reg;
    logic [DATA_W-1:0] data_reg;
    logic              op_reg;
    logic              hit_reg, hit_next;
    logic              rdv_reg;
    logic [AW-1:0]     ptr_reg, ptr_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     occ_reg, occ_next;
    ukf_status_t       st_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [STAT_W-1:0] m_tuser_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic              accept;
    logic              scan_fire;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              out_free;
    logic              emit_fire;
    logic [CW+COUNT_W-1:0] occ_wide;
    logic [WORD_W-1:0] res_word;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] pos);
        return (pos == LAST_POS) ? '0 : pos + 1'b1;
    endfunction

    assign accept    = ctrl.acc && s_tvalid;
    assign scan_fire = ctrl.scan && (cnt_reg != occ_reg);
    assign rd_en     = scan_fire || ctrl.rd_head;
    assign rd_addr   = scan_fire ? ptr_reg : head_reg;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign emit_fire = ctrl.emit && out_free;
    assign occ_wide  = {{COUNT_W{1'b0}}, occ_reg};
    assign res_word  = (st_reg == ST_EMPTY) ? '0 : rd_reg;

    assign flags.in_valid  = s_tvalid;
    assign flags.is_deq    = (op_reg == OP_DEQ);
    assign flags.scan_more = (cnt_reg != occ_reg);
    assign flags.hit       = hit_reg;
    assign flags.full      = (occ_reg == FULL_CNT);
    assign flags.empty     = (occ_reg == '0);
    assign flags.out_free  = out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tdata  = m_tdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr)
            mem[tail_reg] <= {data_reg, key_reg};
        if (rd_en)
            rd_reg <= mem[rd_addr];
    end

    always_comb
    begin
        hit_next  = hit_reg;
        ptr_next  = ptr_reg;
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        occ_next  = occ_reg;
        if (accept)
        begin
            hit_next = 1'b0;
            ptr_next = head_reg;
            cnt_next = '0;
        end
        else
        begin
            // compare the key read in the previous cycle
            if (rdv_reg && (rd_reg[KEY_W-1:0] == key_reg))
                hit_next = 1'b1;
            if (scan_fire)
            begin
                ptr_next = ring_next(ptr_reg);
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (ctrl.wr)
        begin
            tail_next = ring_next(tail_reg);
            occ_next  = occ_reg + 1'b1;
        end
        else if (ctrl.pop)
        begin
            head_next = ring_next(head_reg);
            occ_next  = occ_reg - 1'b1;
        end
        if (emit_fire)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg      <= 1'b0;
            rdv_reg      <= 1'b0;
            ptr_reg      <= '0;
            cnt_reg      <= '0;
            head_reg     <= '0;
            tail_reg     <= '0;
            occ_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            hit_reg      <= hit_next;
            rdv_reg      <= scan_fire;
            ptr_reg      <= ptr_next;
            cnt_reg      <= cnt_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            occ_reg      <= occ_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_tuser[0];
            key_reg  <= s_tdata[KEY_W-1:0];
            data_reg <= s_tdata[KEY_W+DATA_W-1:KEY_W];
        end
        if (ctrl.st_load)
            st_reg <= ctrl.st;
        if (emit_fire)
        begin
            m_tuser_reg <= st_reg;
            m_tdata_reg <= {2'b00, (occ_reg == '0), occ_wide[COUNT_W-1:0], res_word};
        end
    end

endmodule

// ===== rtl/core/ukf_chk.sv =====
`include "unique_key_fifo_core_assert.svh"

module ukf_chk
    import ukf_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [STAT_W-1:0]    m_tuser,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // one item at a time: ready drops straight after an accept
    `UKF_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready,
        "ready held after accept")
    `UKF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result dropped")
    `UKF_ASSERT_NOW(a_empty_zero, m_tvalid && (m_tuser == ST_EMPTY),
        m_tdata[69] && (m_tdata[63:0] == 64'd0), "bad empty result")
    `UKF_ASSERT_NOW(a_dup_held, m_tvalid && ((m_tuser == ST_DUP) || (m_tuser == ST_FULL)),
        !m_tdata[69], "reject with empty queue")
    `UKF_ASSERT_NOW(a_empty_count, m_tvalid && m_tdata[69], m_tdata[68:64] == 5'd0,
        "empty with entries")

endmodule

bind unique_key_fifo_core ukf_chk u_chk (.*);

// ===== tb/unique_key_fifo_check.sv =====
module unique_key_fifo_check
    import ukf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [0:0]           s_tuser,   // [0] opcode
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] item_key, [63:32] item_data
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [STAT_W-1:0]    m_tuser,   // [1:0] status
    input  logic [M_TDATA_W-1:0] m_tdata,   // [31:0] out_key, [63:32] out_data,
                                            // [68:64] entry_count, [69] is_empty
    output int                   fail_count,
    output int                   pending
);

    localparam int IDX_W = $clog2(DEPTH_DEF);

    typedef struct {
        ukf_status_t        status;
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } fifo_result_t;

    logic [KEY_W-1:0]  key_mem  [DEPTH_DEF];
    logic [DATA_W-1:0] data_mem [DEPTH_DEF];
    int head_pos;
    int tail_pos;
    int held;
    int errors = 0;
    fifo_result_t result_q [$];

    // Apply one item to the shadow ring and return the result it should give.
    function automatic fifo_result_t fifo_apply(logic op, logic [KEY_W-1:0] k,
                                                logic [DATA_W-1:0] d);
        fifo_result_t r;
        logic found;
        logic popped;
        int pos;
        found = 1'b0;
        popped = 1'b0;
        pos = head_pos;
        r.key = '0;
        r.data = '0;
        if (op == OP_ENQ)
        begin
            for (int n = 0; n < held; n++)
            begin
                if (key_mem[IDX_W'(pos)] == k)
                    found = 1'b1;
                pos = (pos + 1) % DEPTH_DEF;
            end
            // a duplicate wins over a full ring
            if (found)
                r.status = ST_DUP;
            else if (held >= DEPTH_DEF)
                r.status = ST_FULL;
            else
            begin
                key_mem[IDX_W'(tail_pos)] = k;
                data_mem[IDX_W'(tail_pos)] = d;
                tail_pos = (tail_pos + 1) % DEPTH_DEF;
                held++;
                r.status = ST_OK;
            end
        end
        else if (held == 0)
            r.status = ST_EMPTY;
        else
        begin
            r.key = key_mem[IDX_W'(head_pos)];
            r.data = data_mem[IDX_W'(head_pos)];
            popped = 1'b1;
            head_pos = (head_pos + 1) % DEPTH_DEF;
            held--;
            r.status = ST_OK;
        end
        // otherwise report the head as it stands now
        if (!popped && held != 0)
        begin
            r.key = key_mem[IDX_W'(head_pos)];
            r.data = data_mem[IDX_W'(head_pos)];
        end
        r.count = held[COUNT_W-1:0];
        r.empty = (held == 0);
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fifo_result_t want;
        if (!rst_n)
        begin
            head_pos = 0;
            tail_pos = 0;
            held = 0;
            result_q.delete();
            fail_count <= errors;
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (result_q.size() == 0)
                begin
                    $error("result with no item outstanding: status %0d", m_tuser);
                    errors++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tuser));
                    check_field("out_key", want.key, m_tdata[31:0]);
                    check_field("out_data", want.data, m_tdata[63:32]);
                    check_field("entry_count", 32'(want.count), 32'(m_tdata[68:64]));
                    check_field("is_empty", 32'(want.empty), 32'(m_tdata[69]));
                end
            end
            if (s_tvalid && s_tready)
                result_q.push_back(fifo_apply(s_tuser[0], s_tdata[31:0], s_tdata[63:32]));
            fail_count <= errors;
            pending <= result_q.size();
        end
    end

endmodule

// ===== tb/unique_key_fifo_core_test.sv =====
module unique_key_fifo_core_test
    import ukf_pkg::*;
();

    localparam int ITEM_TOTAL = 1550;
    localparam int IDLE_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 400;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [0:0]           s_tuser = '0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [STAT_W-1:0]    m_tuser;
    logic [M_TDATA_W-1:0] m_tdata;
    int                   fail_count;
    int                   pending;
    int                   idle_cycles = 0;
    bit                   random_phase = 1'b0;

    logic [KEY_W-1:0] key_base;
    int               key_span;

    always #1 clk = ~clk;

    unique_key_fifo_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    unique_key_fifo_check checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tuser    (m_tuser),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    task automatic send_item(logic op, logic [KEY_W-1:0] k, logic [DATA_W-1:0] d);
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {d, k};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic pause_sender(int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles)
            @(posedge clk);
    endtask

    // Drop valid and hold until every outstanding result has been taken.
    task automatic drain_results();
        pause_sender(1);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly keys from a narrow window, so duplicates and a full ring turn up.
    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return key_base + $urandom_range(0, key_span - 1);
    endfunction

    initial
    begin
        int seg_left;
        int burst_left;
        int enq_pct;
        int gap;
        logic op;
        seg_left = 0;
        burst_left = 0;
        enq_pct = 50;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_DEQ, 32'h1234_5678, 32'h9abc_def0);
        send_item(OP_ENQ, 32'h8000_0000, 32'h7fff_ffff);
        send_item(OP_ENQ, 32'h7fff_ffff, 32'h8000_0000);
        send_item(OP_ENQ, 32'h8000_0000, 32'h0000_0001);
        send_item(OP_ENQ, 32'hffff_ffff, 32'h0000_0000);
        send_item(OP_ENQ, 32'h0000_0000, 32'hffff_ffff);
        for (int k = 1; k <= 12; k++)
            send_item(OP_ENQ, k, ~k);
        send_item(OP_ENQ, 32'd100, 32'h5555_aaaa);
        send_item(OP_ENQ, 32'd5, 32'haaaa_5555);
        send_item(OP_DEQ, 32'hffff_ffff, 32'hffff_ffff);
        send_item(OP_ENQ, 32'h8000_0000, 32'h0bad_f00d);
        drain_results();

        random_phase = 1'b1;
        for (int i = 0; i < ITEM_TOTAL; i++)
        begin
            if (seg_left == 0)
            begin
                seg_left = $urandom_range(20, 80);
                case ($urandom_range(0, 3))
                    0: enq_pct = 15;
                    1: enq_pct = 50;
                    2: enq_pct = 75;
                    default: enq_pct = 95;
                endcase
                key_base = $urandom;
                key_span = $urandom_range(2, 40);
            end
            seg_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 40);
                gap = $urandom_range(0, 12);
                if (gap != 0)
                    pause_sender(gap);
            end
            burst_left--;
            op = ($urandom_range(1, 100) <= enq_pct) ? OP_ENQ : OP_DEQ;
            send_item(op, pick_key(), $urandom);
        end
        drain_results();
        repeat (40)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        int span;
        int mode;
        bit held_off;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            // one long hold-off once random traffic is running
            if (random_phase && !held_off)
            begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES)
                    @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 150);
            repeat (span)
            begin
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= 1'($urandom_range(0, 1));
                    2: m_tready <= ($urandom_range(0, 4) == 0);
                    default: m_tready <= ($urandom_range(0, 4) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

endmodule
